// ===== hw/rtl/hng_pkg.sv =====
// Package for the Hamming number generator: widths, seed factors, shared types.
// Used by every module under hw/rtl; depends on nothing.
package hng_pkg;

    localparam int MAX_COUNT   = 64;
    localparam int VALUE_BITS  = 16;
    localparam int FIFO_DEPTH  = 64;
    localparam int IDX_BITS    = $clog2(FIFO_DEPTH);
    localparam int PTR_BITS    = IDX_BITS + 1;
    localparam int COUNT_BITS  = 7;
    localparam int POS_BITS    = 6;
    localparam int FACTOR_BITS = 3;

    typedef logic [VALUE_BITS-1:0]  t_value;
    typedef logic [PTR_BITS-1:0]    t_ptr;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [POS_BITS-1:0]    t_pos;
    typedef logic [FACTOR_BITS-1:0] t_factor;

    localparam t_factor FACTOR_TWO   = 3'd2;
    localparam t_factor FACTOR_THREE = 3'd3;
    localparam t_factor FACTOR_FIVE  = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic seed;
        logic step;
        t_pos position;
        logic last;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_ready;
    } t_dp_stat;

    // value times a small constant, clamped to all ones when it does not fit
    function automatic t_value sat_mul(input t_value v, input t_factor k);
        logic [VALUE_BITS+FACTOR_BITS-1:0] p;
        p = {{FACTOR_BITS{1'b0}}, v} * {{VALUE_BITS{1'b0}}, k};
        return (p[VALUE_BITS+FACTOR_BITS-1:VALUE_BITS] != '0) ? '1 : p[VALUE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/hamming_number_generator_unit.sv =====
// Top level of the Hamming number generator: controller plus datapath.
// Depends on hng_pkg, hng_ctrl, hng_datapath.
//
// Usage:
//   Input channel (i_valid / o_stall, i_count): one request word gives the
//   number of values to emit; counts above 64 are clamped, zero emits nothing.
//   Output channel (o_valid / i_stall): one word per value with o_value,
//   o_position (0-based) and o_last on the final value of the run.
//   Each run restarts the sequence at 2: the three queues are reseeded with
//   2, 3 and 5 in the cycle the request is taken.
//   Timing: the first value is registered by the first step after seeding, then
//   one value per cycle while the receiver does not stall. The pace is set by
//   the head compare and queue update loop, one step per cycle unless stalled.
//   o_stall stays high while a run is in progress; the next request is taken
//   as soon as the last step is issued, even while the last word still waits.
//   When the receiver stalls, the output register holds its word and the
//   stepping pauses until the word is taken.
//   Reset (synchronous, active low) empties the queues and the output register.
module hamming_number_generator_unit
    import hng_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_count i_count,
    output logic   o_valid,
    input  logic   i_stall,
    output t_value o_value,
    output t_pos   o_position,
    output logic   o_last
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    hng_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_count (i_count),
        .o_stall (o_stall),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    hng_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_stall    (i_stall),
        .o_valid    (o_valid),
        .o_value    (o_value),
        .o_position (o_position),
        .o_last     (o_last)
    );

    // a step never overwrites a word still waiting at the output
    a_step_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.step |-> w_stat.out_ready)
        else $error("step issued while output word is held");

    // a nonzero request starts a run that blocks further requests
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_count != '0)) |=> o_stall)
        else $error("accepted request did not start a run");

    // after the final step the input side opens again
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.step && w_cmd.last) |=> !o_stall)
        else $error("run did not end after final value");

    // seeding and stepping never happen together
    a_seed_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.seed |-> !w_cmd.step)
        else $error("seed and step in the same cycle");

endmodule

// ===== hw/rtl/hng_queue.sv =====
// One queue of pending multiples: circular buffer with registered head word.
// Depends on hng_pkg.
module hng_queue
    import hng_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_seed,
    input  t_value i_seed_value,
    input  logic   i_pop,
    input  logic   i_push,
    input  t_value i_push_value,
    output t_value o_head
);

    t_value r_mem [FIFO_DEPTH];
    t_value r_head;
    t_ptr   r_head_ptr, r_tail_ptr;
    t_ptr   n_head_ptr, n_tail_ptr;
    t_ptr   w_fill;
    logic   w_do_push, w_do_pop;

    // pop goes first, so a full queue that pops this cycle still takes the push
    always_comb begin
        w_fill     = r_tail_ptr - r_head_ptr;
        w_do_pop   = i_pop && (w_fill != '0);
        w_do_push  = i_push && ((w_fill != PTR_BITS'(FIFO_DEPTH)) || w_do_pop);
        n_head_ptr = w_do_pop  ? r_head_ptr + t_ptr'(1) : r_head_ptr;
        n_tail_ptr = w_do_push ? r_tail_ptr + t_ptr'(1) : r_tail_ptr;
    end

    assign o_head = (w_fill == '0) ? '1 : r_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_ptr <= '0;
            r_tail_ptr <= '0;
        end else if (i_seed) begin
            r_head_ptr <= '0;
            r_tail_ptr <= t_ptr'(1);
        end else begin
            r_head_ptr <= n_head_ptr;
            r_tail_ptr <= n_tail_ptr;
        end
    end

    // head word is the registered read; a word pushed into an emptied queue is forwarded
    always_ff @(posedge i_clk) begin
        if (i_seed) begin
            r_mem[0] <= i_seed_value;
            r_head   <= i_seed_value;
        end else begin
            if (w_do_push) begin
                r_mem[r_tail_ptr[IDX_BITS-1:0]] <= i_push_value;
            end
            if (w_do_pop) begin
                if (w_do_push && (n_head_ptr == r_tail_ptr)) begin
                    r_head <= i_push_value;
                end else begin
                    r_head <= r_mem[n_head_ptr[IDX_BITS-1:0]];
                end
            end
        end
    end

endmodule

// ===== hw/rtl/hng_datapath.sv =====
// Datapath: three queues, minimum select, multiples, output word register.
// Depends on hng_pkg and hng_queue.
module hng_datapath
    import hng_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_dp_cmd  i_cmd,
    output t_dp_stat o_stat,
    input  logic     i_stall,
    output logic     o_valid,
    output t_value   o_value,
    output t_pos     o_position,
    output logic     o_last
);

    t_value w_head_two, w_head_three, w_head_five;
    t_value w_min;
    logic   r_out_valid;
    t_value r_value;
    t_pos   r_position;
    logic   r_last;

    always_comb begin
        w_min = w_head_two;
        if (w_head_three < w_min) begin
            w_min = w_head_three;
        end
        if (w_head_five < w_min) begin
            w_min = w_head_five;
        end
    end

    hng_queue u_two (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (i_cmd.seed),
        .i_seed_value (VALUE_BITS'(FACTOR_TWO)),
        .i_pop        (i_cmd.step && (w_head_two == w_min)),
        .i_push       (i_cmd.step),
        .i_push_value (sat_mul(w_min, FACTOR_TWO)),
        .o_head       (w_head_two)
    );

    hng_queue u_three (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (i_cmd.seed),
        .i_seed_value (VALUE_BITS'(FACTOR_THREE)),
        .i_pop        (i_cmd.step && (w_head_three == w_min)),
        .i_push       (i_cmd.step),
        .i_push_value (sat_mul(w_min, FACTOR_THREE)),
        .o_head       (w_head_three)
    );

    hng_queue u_five (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seed       (i_cmd.seed),
        .i_seed_value (VALUE_BITS'(FACTOR_FIVE)),
        .i_pop        (i_cmd.step && (w_head_five == w_min)),
        .i_push       (i_cmd.step),
        .i_push_value (sat_mul(w_min, FACTOR_FIVE)),
        .o_head       (w_head_five)
    );

    assign o_stat.out_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step) begin
            r_value    <= w_min;
            r_position <= i_cmd.position;
            r_last     <= i_cmd.last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_value    = r_value;
    assign o_position = r_position;
    assign o_last     = r_last;

endmodule

// ===== hw/rtl/hng_ctrl.sv =====
// Controller: takes a request word, seeds the queues, sequences one step per value.
// Depends on hng_pkg.
module hng_ctrl
    import hng_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_count   i_count,
    output logic     o_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    t_pos   r_pos, n_pos;
    t_pos   r_last_pos, n_last_pos;
    t_count w_count;

    assign w_count = (i_count > COUNT_BITS'(MAX_COUNT)) ? COUNT_BITS'(MAX_COUNT) : i_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pos      <= '0;
            r_last_pos <= '0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_last_pos <= n_last_pos;
        end
    end

    always_comb begin
        n_state        = r_state;
        n_pos          = r_pos;
        n_last_pos     = r_last_pos;
        o_cmd          = '0;
        o_cmd.position = r_pos;
        o_cmd.last     = (r_pos == r_last_pos);
        o_stall        = (r_state == ST_RUN);
        unique case (r_state)
            ST_IDLE: begin
                // a zero count produces nothing
                if (i_valid && (w_count != '0)) begin
                    o_cmd.seed = 1'b1;
                    n_pos      = '0;
                    n_last_pos = POS_BITS'(w_count - t_count'(1));
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                if (i_stat.out_ready) begin
                    o_cmd.step = 1'b1;
                    if (r_pos == r_last_pos) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_pos = r_pos + t_pos'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== sim/hng_word_checker.sv =====
// Checker for the Hamming number generator: watches both channels, predicts
// every output word from the accepted requests and compares field by field.
// Depends on hng_pkg.
module hng_word_checker
    import hng_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    input  logic   i_in_stall,
    input  t_count i_count,
    input  logic   i_out_valid,
    input  logic   i_out_stall,
    input  t_value i_value,
    input  t_pos   i_position,
    input  logic   i_last,
    output int     o_mismatches,
    output int     o_pending
);

    typedef struct packed {
        t_value value;
        t_pos   position;
        logic   last;
    } t_hamming_word;

    t_hamming_word due_words[$];
    int            mismatch_count = 0;

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // v * k, clamped to all ones when it does not fit the value width
    function automatic t_value scaled(input t_value v, input t_factor k);
        logic [VALUE_BITS+FACTOR_BITS:0] p;
        p = {{(FACTOR_BITS+1){1'b0}}, v} * {{(VALUE_BITS+1){1'b0}}, k};
        return (p[VALUE_BITS+FACTOR_BITS:VALUE_BITS] != '0) ? '1 : p[VALUE_BITS-1:0];
    endfunction

    function automatic t_value queue_head(ref t_value q[$]);
        return (q.size() == 0) ? '1 : q[0];
    endfunction

    function automatic void append_bounded(ref t_value q[$], input t_value v);
        if (q.size() < FIFO_DEPTH) begin
            q = {q, v};
        end
    endfunction

    // Three-queue merge: every run restarts from the seeds 2, 3, 5.
    task automatic predict_run(input t_count cnt);
        t_value        by_two[$];
        t_value        by_three[$];
        t_value        by_five[$];
        t_value        low;
        int            n;
        t_hamming_word w;
        n = (int'(cnt) > MAX_COUNT) ? MAX_COUNT : int'(cnt);
        by_two   = {by_two, t_value'(FACTOR_TWO)};
        by_three = {by_three, t_value'(FACTOR_THREE)};
        by_five  = {by_five, t_value'(FACTOR_FIVE)};
        for (int k = 0; k < n; k++) begin
            low = queue_head(by_two);
            if (queue_head(by_three) < low) low = queue_head(by_three);
            if (queue_head(by_five) < low) low = queue_head(by_five);
            // popping every queue that holds the minimum drops duplicates
            if (by_two.size() != 0 && by_two[0] == low) void'(by_two.pop_front());
            if (by_three.size() != 0 && by_three[0] == low) void'(by_three.pop_front());
            if (by_five.size() != 0 && by_five[0] == low) void'(by_five.pop_front());
            append_bounded(by_two, scaled(low, FACTOR_TWO));
            append_bounded(by_three, scaled(low, FACTOR_THREE));
            append_bounded(by_five, scaled(low, FACTOR_FIVE));
            w.value    = low;
            w.position = t_pos'(k);
            w.last     = (k + 1 == n);
            due_words  = {due_words, w};
        end
    endtask

    always @(posedge i_clk) begin
        t_hamming_word want;
        if (!i_rst_n) begin
            due_words.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected word value=%0d position=%0d last=%b",
                                              i_value, i_position, i_last));
                end else begin
                    want = due_words.pop_front();
                    if (i_value !== want.value)
                        report_mismatch($sformatf("value %0d, want %0d (position %0d)",
                                                  i_value, want.value, want.position));
                    if (i_position !== want.position)
                        report_mismatch($sformatf("position %0d, want %0d",
                                                  i_position, want.position));
                    if (i_last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (position %0d)",
                                                  i_last, want.last, want.position));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_run(i_count);
            end
        end
        o_pending    <= due_words.size();
        o_mismatches <= mismatch_count;
    end

endmodule

// ===== sim/hamming_number_generator_unit_test.sv =====
// Testbench top for hamming_number_generator_unit: clock, reset, request and
// stall stimulus, verdict. Depends on hng_pkg, hng_word_checker and the RTL.
module hamming_number_generator_unit_test;
    import hng_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int RANDOM_ITEMS  = 250;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 250000;

    logic   i_clk    = 1'b0;
    logic   i_rst_n  = 1'b0;
    logic   i_valid  = 1'b0;
    t_count i_count  = '0;
    logic   i_stall  = 1'b0;
    logic   o_stall;
    logic   o_valid;
    t_value o_value;
    t_pos   o_position;
    logic   o_last;

    int   mismatches;
    int   pending;
    int   cycle_count = 0;
    logic steady      = 1'b0;  // no idling on either side while set

    hamming_number_generator_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_count    (i_count),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_value    (o_value),
        .o_position (o_position),
        .o_last     (o_last)
    );

    hng_word_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_count      (i_count),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_value      (o_value),
        .i_position   (o_position),
        .i_last       (o_last),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver side: sparse random stalls
    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 6);
    end

    // Called at a rising edge; returns at the edge where the word is taken.
    task automatic send_request(input t_count cnt);
        i_valid <= 1'b1;
        i_count <= cnt;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic t_count random_count();
        int r;
        r = $urandom_range(99);
        if (r < 45) return t_count'($urandom_range(16, 1));
        if (r < 70) return t_count'($urandom_range(64, 17));
        if (r < 85) return t_count'($urandom_range(127, 65));
        if (r < 92) return '0;
        return t_count'(MAX_COUNT);
    endfunction

    t_count directed[$] = '{
        7'd1, 7'd2, 7'd3, 7'd0, 7'd64, 7'd65, 7'd127, 7'd63, 7'd0, 7'd0,
        7'd5, 7'd96, 7'd32, 7'd16, 7'd8, 7'd4, 7'd1, 7'd64, 7'd10, 7'd100,
        7'd31, 7'd42, 7'd85
    };

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, zero and clamped counts, back to back
        foreach (directed[i]) begin
            maybe_idle();
            send_request(directed[i]);
        end
        wait_for_drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            steady = (i >= 120 && i < 170);
            if (i == 200) wait_for_drain();
            maybe_idle();
            send_request(random_count());
        end
        steady = 1'b0;

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/hng_pkg.sv
hw/rtl/hng_queue.sv
hw/rtl/hng_datapath.sv
hw/rtl/hng_ctrl.sv
hw/rtl/hamming_number_generator_unit.sv
sim/hng_word_checker.sv
sim/hamming_number_generator_unit_test.sv
